// ----- rtl/trnm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trnm_pkg
// shared constants and types for the timestamp ring nearest-match block
// ----------------------------------------------------------------------------
package trnm_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int TS_W     = 32;
  localparam int NPT_W    = 8;
  localparam int WIN_W    = 30;
  localparam int DIFF_W   = TS_W + NPT_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = WIN_W;

  localparam logic [NPT_W-1:0] TICK_NS_RST   = 8'd12;
  localparam logic [WIN_W-1:0] WINDOW_NS_RST = 30'd10000000;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_NS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_NS = 1'd1;

  localparam logic ACT_CAPTURE = 1'b0;
  localparam logic ACT_LOOKUP  = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              cand;
    logic [DIFF_W-1:0] diff_ns;
    logic [TS_W-1:0]   ts;
  } score_t;

endpackage
`default_nettype wire

// ----- rtl/trnm_score.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trnm_score
// registered candidate test and scaled difference for one stored entry
// ----------------------------------------------------------------------------
module trnm_score (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [trnm_pkg::TS_W-1:0]     ts,
  input  wire logic [trnm_pkg::TS_W-1:0]     q,
  input  wire logic [trnm_pkg::NPT_W-1:0]    tick_ns,
  output trnm_pkg::score_t                   score
);

  logic [trnm_pkg::TS_W-1:0]   delta;
  logic [trnm_pkg::DIFF_W-1:0] prod;

  assign delta = ts - q;
  assign prod  = trnm_pkg::DIFF_W'(delta) * trnm_pkg::DIFF_W'(tick_ns);

  always_ff @(posedge clk) begin
    if (rst) begin
      score.valid <= 1'b0;
    end else begin
      score.valid <= in_valid;
    end
    score.cand    <= (ts >= q);
    score.diff_ns <= prod;
    score.ts      <= ts;
  end

endmodule
`default_nettype wire

// ----- rtl/timestamp_ring_nearest_match.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_ring_nearest_match
// capture ring of counter snapshots with nearest-later-or-equal lookup
//
//   channel  signals                               direction  transfer
//   input    start, busy, action, counter_value   in         start & !busy
//   config   cfg_valid, cfg_ready, cfg_index,     in         cfg_valid & cfg_ready
//            cfg_data
//   result   done, found, match_ts                 out        done (one cycle)
//
// a capture is written to the ring while busy stays low
// a lookup holds busy while it reads the held entries (held = entries in
// the ring), one memory read per entry, and drains the multiply and compare
// stages; on an empty ring busy stays high for one cycle
// synchronous reset empties the ring and loads the register defaults
// results cannot be stalled; done pulses for one cycle per lookup
// ----------------------------------------------------------------------------
module timestamp_ring_nearest_match #(
  parameter int DEPTH = trnm_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic                              action,
  input  wire logic [trnm_pkg::TS_W-1:0]         counter_value,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [trnm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [trnm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output      logic                              done,
  output      logic                              found,
  output      logic [trnm_pkg::TS_W-1:0]         match_ts
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [trnm_pkg::TS_W-1:0] mem [DEPTH];

  logic [1:0]                   state;
  logic [PTR_W-1:0]             write_ptr;
  logic [PTR_W-1:0]             read_ptr;
  logic [PTR_W-1:0]             write_ptr_next;
  logic [PTR_W-1:0]             held;
  logic [PTR_W-1:0]             slot;
  logic [PTR_W-1:0]             remain;
  logic [trnm_pkg::NPT_W-1:0]   tick_ns;
  logic [trnm_pkg::WIN_W-1:0]   window_ns;
  logic [trnm_pkg::TS_W-1:0]    q;
  logic [trnm_pkg::TS_W-1:0]    rd_data;
  logic                         rd_valid;
  logic                         hit;
  logic [trnm_pkg::DIFF_W-1:0]  best_ns;
  logic [trnm_pkg::TS_W-1:0]    best;
  logic                         accept;
  logic                         better;
  trnm_pkg::score_t             score;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign write_ptr_next = (write_ptr == LAST) ? '0 : write_ptr + 1'b1;
  assign held = (write_ptr >= read_ptr) ? PTR_W'(write_ptr - read_ptr)
                                        : PTR_W'(write_ptr + PTR_W'(DEPTH) - read_ptr);

  assign better = score.valid && score.cand &&
                  (score.diff_ns < trnm_pkg::DIFF_W'(window_ns)) &&
                  (!hit || (score.diff_ns < best_ns));

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ns   <= trnm_pkg::TICK_NS_RST;
      window_ns <= trnm_pkg::WINDOW_NS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        trnm_pkg::CFG_TICK_NS:   tick_ns   <= cfg_data[trnm_pkg::NPT_W-1:0];
        trnm_pkg::CFG_WINDOW_NS: window_ns <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture store
  always_ff @(posedge clk) begin
    if (accept && (action == trnm_pkg::ACT_CAPTURE)) begin
      mem[write_ptr] <= counter_value;
    end
    rd_data <= mem[slot];
  end

  trnm_score u_score (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (rd_valid),
    .ts          (rd_data),
    .q           (q),
    .tick_ns     (tick_ns),
    .score       (score)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      write_ptr <= '0;
      read_ptr  <= '0;
      rd_valid  <= 1'b0;
      done      <= 1'b0;
      hit       <= 1'b0;
      slot      <= '0;
      remain    <= '0;
    end else begin
      done     <= 1'b0;
      rd_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (action == trnm_pkg::ACT_CAPTURE) begin
              write_ptr <= write_ptr_next;
              if (write_ptr_next == read_ptr) begin
                read_ptr <= (read_ptr == LAST) ? '0 : read_ptr + 1'b1;
              end
            end else begin
              slot   <= (write_ptr == '0) ? LAST : write_ptr - 1'b1;
              remain <= held;
              hit    <= 1'b0;
              state  <= (held == '0) ? ST_DRAIN : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_valid <= 1'b1;
          slot     <= (slot == '0) ? LAST : slot - 1'b1;
          remain   <= remain - 1'b1;
          if (remain == PTR_W'(1)) begin
            state <= ST_DRAIN;
          end
          if (better) begin
            hit <= 1'b1;
          end
        end
        ST_DRAIN: begin
          if (better) begin
            hit <= 1'b1;
          end
          if (!rd_valid && !score.valid) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // lookup datapath
  always_ff @(posedge clk) begin
    if (accept && (action == trnm_pkg::ACT_LOOKUP)) begin
      q <= counter_value;
    end
    if (better) begin
      best_ns <= score.diff_ns;
      best    <= score.ts;
    end
    if ((state == ST_DRAIN) && !rd_valid && !score.valid) begin
      found    <= hit;
      match_ts <= hit ? best : q;
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a lookup is in progress");

  a_miss_query: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (match_ts == q))
    else $error("miss does not return the query value");

  a_busy_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && (action == trnm_pkg::ACT_LOOKUP)))
    else $error("busy raised without a lookup transfer");

  a_no_read_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |=> !score.valid || $past(rd_valid))
    else $error("score stage active without a preceding read");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for timestamp_ring_nearest_match: directed captures and
// lookups on the empty, partly filled and overflowed ring, then random phases
// under several tick_ns / window_ns settings; a bench-side copy of the
// ring predicts every lookup and a monitor checks each done pulse in order
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PTR_W        = $clog2(trnm_pkg::DEPTH_DEF);
  localparam int WDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = trnm_pkg::DEPTH_DEF + 8;

  typedef struct {
    logic                      found;
    logic [trnm_pkg::TS_W-1:0] rx;
  } match_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            start;
  logic                            busy;
  logic                            action;
  logic [trnm_pkg::TS_W-1:0]       counter_value;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [trnm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [trnm_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            done;
  logic                            found;
  logic [trnm_pkg::TS_W-1:0]       match_ts;

  logic [trnm_pkg::TS_W-1:0]  ring_ts [trnm_pkg::DEPTH_DEF];
  logic [PTR_W-1:0]           ring_wr;
  logic [PTR_W-1:0]           ring_rd;
  logic [trnm_pkg::NPT_W-1:0] cur_npt;
  logic [trnm_pkg::WIN_W-1:0] cur_win;
  match_t                     match_q [$];
  int                         err_count;
  int                         idle_cycles;

  timestamp_ring_nearest_match #(
    .DEPTH(trnm_pkg::DEPTH_DEF)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .counter_value(counter_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .found        (found),
    .match_ts     (match_ts)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // capture updates the ring, lookup queues the nearest later-or-equal entry
  task automatic apply_to_ring(input logic act, input logic [trnm_pkg::TS_W-1:0] val);
    logic [PTR_W-1:0]            held;
    logic [PTR_W-1:0]            slot;
    logic [trnm_pkg::DIFF_W-1:0] diff;
    logic [trnm_pkg::DIFF_W-1:0] best;
    match_t                      m;
    int                          i;
    if (act == trnm_pkg::ACT_CAPTURE) begin
      ring_ts[ring_wr] = val;
      ring_wr = ring_wr + 1'b1;
      if (ring_wr == ring_rd) ring_rd = ring_rd + 1'b1;
    end else begin
      held = ring_wr - ring_rd;
      best = '1;
      m.found = 1'b0;
      m.rx = val;
      for (i = 0; i < held; i++) begin
        slot = ring_wr - 1'b1 - i[PTR_W-1:0];
        if (ring_ts[slot] >= val) begin
          diff = trnm_pkg::DIFF_W'(ring_ts[slot] - val) * trnm_pkg::DIFF_W'(cur_npt);
          if (diff < trnm_pkg::DIFF_W'(cur_win) && diff < best) begin
            best = diff;
            m.found = 1'b1;
            m.rx = ring_ts[slot];
          end
        end
      end
      match_q.push_back(m);
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic act, input logic [trnm_pkg::TS_W-1:0] val);
    start = 1'b1;
    action = act;
    counter_value = val;
    do @(posedge clk); while (busy);
    apply_to_ring(act, val);
    @(negedge clk);
  endtask

  task automatic idle_burst();
    start = 1'b0;
    repeat ($urandom_range(1, 5)) @(negedge clk);
  endtask

  task automatic write_reg(input logic [trnm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [trnm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == trnm_pkg::CFG_TICK_NS) cur_npt = data[trnm_pkg::NPT_W-1:0];
    else cur_win = data[trnm_pkg::WIN_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (match_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_empty_lookup();
    send_item(trnm_pkg::ACT_LOOKUP, 32'h0000_0000);
    send_item(trnm_pkg::ACT_LOOKUP, 32'hFFFF_FFFF);
  endtask

  // extremes, a tie on equal captures, and a query just past the nearest
  task automatic test_capture_and_tie();
    send_item(trnm_pkg::ACT_CAPTURE, 32'hFFFF_FFFF);
    send_item(trnm_pkg::ACT_CAPTURE, 32'h0000_0000);
    send_item(trnm_pkg::ACT_CAPTURE, 32'd1000);
    send_item(trnm_pkg::ACT_CAPTURE, 32'd1000);
    send_item(trnm_pkg::ACT_LOOKUP, 32'd990);
    send_item(trnm_pkg::ACT_LOOKUP, 32'd1001);
    send_item(trnm_pkg::ACT_LOOKUP, 32'h0000_0000);
  endtask

  // fill to capacity, then push the oldest entry out
  task automatic test_ring_overflow();
    int i;
    for (i = 0; i < trnm_pkg::DEPTH_DEF - 5; i++)
      send_item(trnm_pkg::ACT_CAPTURE, 32'd2000 + 32'(10 * i));
    send_item(trnm_pkg::ACT_LOOKUP, 32'hFFFF_FFFF);
    send_item(trnm_pkg::ACT_CAPTURE, 32'd5000);
    send_item(trnm_pkg::ACT_LOOKUP, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_phase(input logic [trnm_pkg::NPT_W-1:0] npt,
                                   input logic [trnm_pkg::WIN_W-1:0] win,
                                   input bit idle_en, input int n_items);
    logic [trnm_pkg::CFG_DATA_W-1:0] wdata;
    logic [trnm_pkg::TS_W-1:0]       spread;
    logic [trnm_pkg::TS_W-1:0]       base;
    logic [trnm_pkg::TS_W-1:0]       val;
    logic [PTR_W-1:0]                held;
    logic [PTR_W-1:0]                off;
    longint                          ticks;
    int                              k;
    int                              pick;
    int                              sub;
    bit                              calm;
    wait_drained();
    wdata = trnm_pkg::CFG_DATA_W'($urandom);
    wdata[trnm_pkg::NPT_W-1:0] = npt;
    write_reg(trnm_pkg::CFG_TICK_NS, wdata);
    write_reg(trnm_pkg::CFG_WINDOW_NS, win);
    ticks = (npt == 0) ? (64'd1 << 20) : (longint'(win) / longint'(npt)) * 2;
    if (ticks < 4) ticks = 4;
    if (ticks > (64'd1 << 31)) ticks = 64'd1 << 31;
    spread = ticks[trnm_pkg::TS_W-1:0];
    base = $urandom;
    calm = 1'b0;
    for (k = 0; k < n_items; k++) begin
      if (k % 32 == 0) calm = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      sub = $urandom_range(0, 9);
      held = ring_wr - ring_rd;
      off = (held == 0) ? '0 : PTR_W'($urandom_range(0, held - 1));
      if (pick < 45) begin
        if (sub < 7) begin
          val = base - $urandom_range(0, spread);
          base = base - $urandom_range(0, spread / 4);
        end else if (sub < 9 || held == 0) begin
          val = $urandom;
        end else begin
          val = ring_ts[ring_wr - 1'b1 - off];
        end
        send_item(trnm_pkg::ACT_CAPTURE, val);
      end else begin
        if (sub < 5 && held != 0) begin
          val = ring_ts[ring_wr - 1'b1 - off] - $urandom_range(0, spread);
        end else if (sub == 5 && held != 0) begin
          val = ring_ts[ring_wr - 1'b1 - off] + 1'b1;
        end else if (sub < 8) begin
          val = base - $urandom_range(0, spread);
        end else begin
          val = $urandom;
        end
        send_item(trnm_pkg::ACT_LOOKUP, val);
      end
      if (idle_en && !calm && $urandom_range(0, 3) == 0) idle_burst();
    end
  endtask

  always @(posedge clk) begin
    match_t head;
    if (!rst && done) begin
      if (match_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b match_ts=%h",
                                  found, match_ts));
      end else begin
        head = match_q.pop_front();
        if (found !== head.found)
          report_mismatch($sformatf("found %0b, want %0b", found, head.found));
        if (match_ts !== head.rx)
          report_mismatch($sformatf("match_ts %h, want %h", match_ts, head.rx));
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("timestamp_ring_nearest_match: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = trnm_pkg::ACT_CAPTURE;
    counter_value = '0;
    cfg_valid = 1'b0;
    cfg_index = trnm_pkg::CFG_TICK_NS;
    cfg_data = '0;
    ring_wr = '0;
    ring_rd = '0;
    cur_npt = trnm_pkg::TICK_NS_RST;
    cur_win = trnm_pkg::WINDOW_NS_RST;
    err_count = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_lookup();
    test_capture_and_tie();
    test_ring_overflow();
    test_random_phase(8'd1, 30'd1, 1'b1, 255);
    test_random_phase(8'd255, 30'd1000000000, 1'b1, 255);
    test_random_phase(8'd0, 30'd5000, 1'b1, 255);
    test_random_phase(8'd37, 30'd0, 1'b1, 255);
    test_random_phase(8'd3, 30'h3FFF_FFFF, 1'b1, 255);
    test_random_phase(8'd12, 30'd10000000, 1'b0, 255);

    wait_drained();
    if (err_count == 0) begin
      $display("timestamp_ring_nearest_match: match");
    end else begin
      $display("timestamp_ring_nearest_match: mismatch");
    end
    $finish;
  end

endmodule
